// ===== rtl/hill_block_encryptor_defines.svh =====
// assertion helpers shared by the pair unit and the output buffer
`ifndef HILL_BLOCK_ENCRYPTOR_DEFINES_SVH
`define HILL_BLOCK_ENCRYPTOR_DEFINES_SVH

// checked on every clock edge outside reset
`define HBE_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// checked on every clock edge, reset included
`define HBE_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// ===== rtl/hbe_pkg.sv =====
`default_nettype none
package hbe_pkg;

  localparam int unsigned SymW   = 5;
  localparam int unsigned SymMod = 27;
  localparam int unsigned AddrW  = 4;
  localparam int unsigned DataW  = 32;

  localparam logic [SymW-1:0] PadSymbol = '0;

  typedef enum logic [1:0] {
    RegKey00 = 2'd0,
    RegKey01 = 2'd1,
    RegKey10 = 2'd2,
    RegKey11 = 2'd3
  } reg_idx_e;

  typedef struct packed {
    logic [SymW-1:0] k00;
    logic [SymW-1:0] k01;
    logic [SymW-1:0] k10;
    logic [SymW-1:0] k11;
  } key_t;

  typedef struct packed {
    logic [SymW-1:0] c0;
    logic [SymW-1:0] c1;
  } pair_t;

  // a 5 bit value is below twice the modulus
  function automatic logic [SymW-1:0] red27(input logic [SymW-1:0] v);
    logic [SymW-1:0] r;
    if (v >= SymW'(SymMod)) begin
      r = v - SymW'(SymMod);
    end else begin
      r = v;
    end
    return r;
  endfunction

  // v < 2048; fold by 64 = 10 mod 27 twice, then subtract at most three times the modulus
  function automatic logic [SymW-1:0] mod27_11(input logic [10:0] v);
    logic [8:0] s1;
    logic [6:0] s2;
    logic [6:0] r;
    s1 = 9'({v[10:6], 3'b000}) + 9'({v[10:6], 1'b0}) + 9'(v[5:0]);
    s2 = 7'({s1[8:6], 3'b000}) + 7'({s1[8:6], 1'b0}) + 7'(s1[5:0]);
    if (s2 >= 7'(3 * SymMod)) begin
      r = s2 - 7'(3 * SymMod);
    end else if (s2 >= 7'(2 * SymMod)) begin
      r = s2 - 7'(2 * SymMod);
    end else if (s2 >= 7'(SymMod)) begin
      r = s2 - 7'(SymMod);
    end else begin
      r = s2;
    end
    return r[SymW-1:0];
  endfunction

  function automatic logic [SymW-1:0] row_mod27(input logic [SymW-1:0] ka,
                                                input logic [SymW-1:0] kb,
                                                input logic [SymW-1:0] a,
                                                input logic [SymW-1:0] b);
    logic [9:0]  pa;
    logic [9:0]  pb;
    logic [10:0] s;
    pa = 10'(red27(ka)) * 10'(a);
    pb = 10'(red27(kb)) * 10'(b);
    s  = 11'(pa) + 11'(pb);
    return mod27_11(s);
  endfunction

endpackage
`default_nettype wire

// ===== rtl/hbe_cfg_regs.sv =====
`default_nettype none
module hbe_cfg_regs
  import hbe_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             psel,
  input  wire logic             penable,
  input  wire logic             pwrite,
  input  wire logic [AddrW-1:0] paddr,
  input  wire logic [DataW-1:0] pwdata,
  output logic      [DataW-1:0] prdata,
  output logic                  pready,
  output key_t                  key_o
);

  key_t     key_q, key_d;
  logic     wr_en;
  reg_idx_e idx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign idx    = reg_idx_e'(paddr[3:2]);

  always_comb begin
    key_d = key_q;
    if (wr_en) begin
      case (idx)
        RegKey00: key_d.k00 = pwdata[SymW-1:0];
        RegKey01: key_d.k01 = pwdata[SymW-1:0];
        RegKey10: key_d.k10 = pwdata[SymW-1:0];
        RegKey11: key_d.k11 = pwdata[SymW-1:0];
        default:  key_d = key_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q.k00 <= SymW'(1);
      key_q.k01 <= '0;
      key_q.k10 <= '0;
      key_q.k11 <= SymW'(1);
    end else begin
      key_q <= key_d;
    end
  end

  always_comb begin
    case (idx)
      RegKey00: prdata = DataW'(key_q.k00);
      RegKey01: prdata = DataW'(key_q.k01);
      RegKey10: prdata = DataW'(key_q.k10);
      RegKey11: prdata = DataW'(key_q.k11);
      default:  prdata = '0;
    endcase
  end

  assign key_o = key_q;

endmodule
`default_nettype wire

// ===== rtl/hbe_pair_unit.sv =====
`default_nettype none
module hbe_pair_unit
  import hbe_pkg::*;
(
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_stall_o,
  input  wire logic [SymW-1:0] symbol_i,
  input  wire logic            end_of_message_i,
  input  wire key_t            key_i,
  output logic                 pair_valid_o,
  input  wire logic            pair_ready_i,
  output pair_t                pair_o
);

  `include "hill_block_encryptor_defines.svh"

  logic            in_vld_q, in_vld_d;
  logic [SymW-1:0] in_sym_q;
  logic            in_eom_q;
  logic            half_q, half_d;
  logic [SymW-1:0] held_q, held_d;
  logic            pair_needed;
  logic            in_take;
  logic            in_load;
  logic [SymW-1:0] sym_a;
  logic [SymW-1:0] sym_b;

  assign pair_needed = half_q | in_eom_q;
  assign in_take     = in_vld_q & (~pair_needed | pair_ready_i);
  assign in_load     = ~in_vld_q | in_take;
  assign in_stall_o  = ~in_load;

  assign in_vld_d = in_load ? in_valid_i : in_vld_q;

  always_comb begin
    half_d = half_q;
    held_d = held_q;
    if (in_take) begin
      if (pair_needed) begin
        half_d = 1'b0;
        held_d = '0;
      end else begin
        half_d = 1'b1;
        held_d = in_sym_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
      half_q   <= 1'b0;
      held_q   <= '0;
    end else begin
      in_vld_q <= in_vld_d;
      half_q   <= half_d;
      held_q   <= held_d;
    end
  end

  // symbol is reduced on the way in
  always_ff @(posedge clk_i) begin
    if (in_load && in_valid_i) begin
      in_sym_q <= red27(symbol_i);
      in_eom_q <= end_of_message_i;
    end
  end

  // a lone final symbol pairs with the padding symbol
  assign sym_a = half_q ? held_q : in_sym_q;
  assign sym_b = half_q ? in_sym_q : PadSymbol;

  assign pair_valid_o = in_vld_q & pair_needed;
  assign pair_o.c0    = row_mod27(key_i.k00, key_i.k01, sym_a, sym_b);
  assign pair_o.c1    = row_mod27(key_i.k10, key_i.k11, sym_a, sym_b);

  `HBE_ASSERT(a_pair_clears_half, pair_valid_o && pair_ready_i |=> !half_q,
              "held symbol survived a completed pair")
  `HBE_ASSERT(a_held_in_range, half_q |-> held_q < SymW'(SymMod),
              "held symbol out of range")
  `HBE_ASSERT(a_stall_needs_item, in_stall_o |-> in_vld_q && pair_valid_o,
              "stall without a pending pair")

endmodule
`default_nettype wire

// ===== rtl/hbe_out_buf.sv =====
`default_nettype none
module hbe_out_buf
  import hbe_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      pair_valid_i,
  output logic           pair_ready_o,
  input  wire pair_t     pair_i,
  output logic           out_valid_o,
  input  wire logic      out_stall_i,
  output logic [SymW-1:0] cipher_symbol_o,
  output logic           last_of_block_o
);

  `include "hill_block_encryptor_defines.svh"

  logic  vld_q, vld_d;
  logic  second_q, second_d;
  pair_t pair_q;
  logic  out_take;
  logic  load;

  assign out_take     = vld_q & ~out_stall_i;
  // free once empty or when the second symbol leaves
  assign pair_ready_o = ~vld_q | (second_q & out_take);
  assign load         = pair_valid_i & pair_ready_o;

  always_comb begin
    vld_d    = vld_q;
    second_d = second_q;
    if (load) begin
      vld_d    = 1'b1;
      second_d = 1'b0;
    end else if (out_take) begin
      if (second_q) begin
        vld_d    = 1'b0;
        second_d = 1'b0;
      end else begin
        second_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= 1'b0;
      second_q <= 1'b0;
    end else begin
      vld_q    <= vld_d;
      second_q <= second_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      pair_q <= pair_i;
    end
  end

  assign out_valid_o     = vld_q;
  assign cipher_symbol_o = second_q ? pair_q.c1 : pair_q.c0;
  assign last_of_block_o = second_q;

  `HBE_ASSERT(a_second_follows, out_valid_o && !out_stall_i && !last_of_block_o |=>
              out_valid_o && last_of_block_o, "second symbol of pair missing")
  `HBE_ASSERT(a_cipher_in_range, out_valid_o |-> cipher_symbol_o < SymW'(SymMod),
              "cipher symbol out of range")
  `HBE_ASSERT_ALWAYS(a_second_needs_valid, second_q |-> vld_q,
                     "second flag set on empty buffer")

endmodule
`default_nettype wire

// ===== rtl/hill_block_encryptor.sv =====
// the request carrying the second symbol of a pair is registered in the pair unit, and the pair
// is registered in the output buffer; one symbol request per cycle unless in_stall_o is high
// a pair leaves from one result register, c0 then c1; a lone final symbol yields two results
// reset: key is the identity matrix, no symbol held, no result pending
`default_nettype none
module hill_block_encryptor
  import hbe_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             psel,
  input  wire logic             penable,
  input  wire logic             pwrite,
  input  wire logic [AddrW-1:0] paddr,
  input  wire logic [DataW-1:0] pwdata,
  output logic      [DataW-1:0] prdata,
  output logic                  pready,
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  wire logic [SymW-1:0]  symbol_i,
  input  wire logic             end_of_message_i,
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output logic      [SymW-1:0]  cipher_symbol_o,
  output logic                  last_of_block_o
);

  key_t  key;
  pair_t pair;
  logic  pair_valid;
  logic  pair_ready;

  hbe_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .key_o   (key)
  );

  hbe_pair_unit u_pair (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .symbol_i         (symbol_i),
    .end_of_message_i (end_of_message_i),
    .key_i            (key),
    .pair_valid_o     (pair_valid),
    .pair_ready_i     (pair_ready),
    .pair_o           (pair)
  );

  hbe_out_buf u_out (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .pair_valid_i    (pair_valid),
    .pair_ready_o    (pair_ready),
    .pair_i          (pair),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .cipher_symbol_o (cipher_symbol_o),
    .last_of_block_o (last_of_block_o)
  );

endmodule
`default_nettype wire
